FILE: rtl/core/strict_base64_decoder_assert.svh
// Assertion macros for the strict base64 decoder.
// Included by the modules that check their own logic; no other dependencies.
`ifndef STRICT_BASE64_DECODER_ASSERT_SVH
`define STRICT_BASE64_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define SBD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sbd assertion failed");
// Clocked check that also holds during reset.
`define SBD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("sbd assertion failed");
`else
`define SBD_ASSERT(lbl, clk, rst_n, prop)
`define SBD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/sbd_pkg.sv
// Shared types, constants and the character classifier of the strict base64 decoder.
// No dependencies.
package sbd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned CLASS_W  = 7;
    localparam int unsigned SEXTET_W = 6;
    localparam int unsigned ACCUM_W  = 3 * SEXTET_W;
    localparam int unsigned GROUP_W  = 4 * SEXTET_W;

    localparam logic [CLASS_W-1:0] CLASS_PAD = 7'd64;
    localparam logic [CLASS_W-1:0] CLASS_BAD = 7'd65;

    localparam logic [1:0] POS_LAST = 2'd3;

    // One queued unit of work: a decoded group or an error.
    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [1:0]         nbytes;
        logic               error;
        logic               msg_last;
    } job_t;

    function automatic logic [CLASS_W-1:0] classify(input logic [CHAR_W-1:0] c);
        logic [CLASS_W-1:0] cls;
        cls = CLASS_BAD;
        if (c inside {[8'h41:8'h5A]}) begin
            cls = CLASS_W'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            cls = CLASS_W'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            cls = CLASS_W'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            cls = 7'd62;
        end else if (c == 8'h2F) begin
            cls = 7'd63;
        end else if (c == 8'h3D) begin
            cls = CLASS_PAD;
        end
        return cls;
    endfunction

endpackage

FILE: rtl/core/sbd_front.sv
// Front end: accepts characters, checks the group rules and issues decode jobs.
// Depends on sbd_pkg and strict_base64_decoder_assert.svh.
`include "strict_base64_decoder_assert.svh"
module sbd_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sbd_pkg::CHAR_W-1:0]   in_char,
    input  logic                         in_last,
    output logic                         push,
    output sbd_pkg::job_t                push_job,
    input  logic                         queue_full
);

    logic [sbd_pkg::ACCUM_W-1:0] accum_reg, accum_next;
    logic [1:0]                  pos_reg, pos_next;
    logic [1:0]                  pad_reg, pad_next;
    logic                        discard_reg, discard_next;

    logic [sbd_pkg::CLASS_W-1:0]  cls;
    logic                         is_pad;
    logic                         is_bad;
    logic [1:0]                   pad_inc;
    logic [sbd_pkg::SEXTET_W-1:0] sextet;
    logic                         err;
    logic                         accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    assign cls     = sbd_pkg::classify(in_char);
    assign is_pad  = (cls == sbd_pkg::CLASS_PAD);
    assign is_bad  = (cls == sbd_pkg::CLASS_BAD);
    assign pad_inc = pad_reg + {1'b0, is_pad};
    assign sextet  = (is_pad || is_bad) ? '0 : cls[sbd_pkg::SEXTET_W-1:0];

    always_comb begin
        err = is_bad
            || (is_pad && pad_reg >= 2'd2)
            || (!is_pad && pad_reg != 2'd0)
            || (pos_reg != sbd_pkg::POS_LAST && in_last)
            || (pos_reg == sbd_pkg::POS_LAST && pad_inc != 2'd0 && !in_last);
    end

    always_comb begin
        accum_next   = accum_reg;
        pos_next     = pos_reg;
        pad_next     = pad_reg;
        discard_next = discard_reg;
        push         = 1'b0;
        push_job     = '0;
        if (accept) begin
            if (discard_reg) begin
                if (in_last) begin
                    discard_next = 1'b0;
                end
            end else if (err) begin
                push              = 1'b1;
                push_job.error    = 1'b1;
                push_job.nbytes   = 2'd1;
                push_job.msg_last = 1'b1;
                accum_next        = '0;
                pos_next          = '0;
                pad_next          = '0;
                discard_next      = !in_last;
            end else if (pos_reg != sbd_pkg::POS_LAST) begin
                accum_next = {accum_reg[sbd_pkg::ACCUM_W-sbd_pkg::SEXTET_W-1:0], sextet};
                pos_next   = pos_reg + 2'd1;
                pad_next   = pad_inc;
            end else begin
                push              = 1'b1;
                push_job.group    = {accum_reg, sextet};
                push_job.nbytes   = 2'd3 - pad_inc;
                push_job.msg_last = in_last;
                accum_next        = '0;
                pos_next          = '0;
                pad_next          = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg   <= '0;
            pos_reg     <= '0;
            pad_reg     <= '0;
            discard_reg <= 1'b0;
        end else begin
            accum_reg   <= accum_next;
            pos_reg     <= pos_next;
            pad_reg     <= pad_next;
            discard_reg <= discard_next;
        end
    end

    // nothing is gathered while dropping input after an error
    `SBD_ASSERT(a_discard_clear, aclk, aresetn, discard_reg |-> (pos_reg == 2'd0 && pad_reg == 2'd0))

endmodule

FILE: rtl/core/sbd_queue.sv
// Short job queue between the front end and the byte sequencer.
// Depends on sbd_pkg and strict_base64_decoder_assert.svh.
`include "strict_base64_decoder_assert.svh"
module sbd_queue #(
    parameter int unsigned DEPTH = sbd_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sbd_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output sbd_pkg::job_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sbd_pkg::job_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    `SBD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `SBD_ASSERT(a_no_push_full, aclk, aresetn, push |-> !full)

endmodule

FILE: rtl/core/sbd_back.sv
// Back end: sends queued jobs as bytes, one per cycle unless stalled.
// Depends on sbd_pkg and strict_base64_decoder_assert.svh.
`include "strict_base64_decoder_assert.svh"
module sbd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          empty,
    input  sbd_pkg::job_t head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_error,
    output logic          out_run_end,
    output logic          out_msg_end
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       error_reg, error_next;
    logic       run_end_reg, run_end_next;
    logic       msg_end_reg, msg_end_next;

    logic       advance;
    logic       fin;
    logic [7:0] sel_byte;

    assign advance = !valid_reg || out_ready;
    assign fin     = ((idx_reg + 2'd1) == head.nbytes);

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = head.group[23:16];
            2'd1:    sel_byte = head.group[15:8];
            2'd2:    sel_byte = head.group[7:0];
            default: sel_byte = '0;
        endcase
    end

    always_comb begin
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        error_next   = error_reg;
        run_end_next = run_end_reg;
        msg_end_next = msg_end_reg;
        pop          = 1'b0;
        if (advance) begin
            valid_next = !empty;
            if (!empty) begin
                byte_next    = head.error ? 8'd0 : sel_byte;
                error_next   = head.error;
                run_end_next = fin;
                msg_end_next = fin && head.msg_last;
                if (fin) begin
                    pop      = 1'b1;
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        error_reg   <= error_next;
        run_end_reg <= run_end_next;
        msg_end_reg <= msg_end_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_error   = error_reg;
    assign out_run_end = run_end_reg;
    assign out_msg_end = msg_end_reg;

    `SBD_ASSERT(a_idx_in_job, aclk, aresetn, !empty |-> (idx_reg < head.nbytes))
    `SBD_ASSERT(a_error_ends, aclk, aresetn,
        (valid_reg && error_reg) |-> (run_end_reg && msg_end_reg && byte_reg == 8'd0))

endmodule

FILE: rtl/core/strict_base64_decoder.sv
// Top level of the strict base64 decoder: front end, job queue and byte sequencer.
// Depends on sbd_pkg, sbd_front, sbd_queue and sbd_back.
//
//  channel  dir  data                  user                     last
//  s_       in   char_in [7:0]         -                        last_char
//  m_       out  data_byte [7:0]       error_flag, run_end      message_end
//
// One character is taken per cycle while the queue has room; result bytes are
// registered and leave one per cycle while m_ is ready (three per group at most).
// The queue of QUEUE_DEPTH jobs sets how long the input runs on while m_ stalls.
// Reset is synchronous, active low, and empties the queue and group state.
module strict_base64_decoder #(
    parameter int unsigned QUEUE_DEPTH = sbd_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic [1:0] m_tuser,   // [0] error_flag, [1] run_end
    output logic       m_tlast
);

    logic          push;
    sbd_pkg::job_t push_job;
    logic          queue_full;
    logic          queue_empty;
    logic          pop;
    sbd_pkg::job_t head;
    logic          out_error;
    logic          out_run_end;

    sbd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_job   (push_job),
        .queue_full (queue_full)
    );

    sbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    sbd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .empty       (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .out_error   (out_error),
        .out_run_end (out_run_end),
        .out_msg_end (m_tlast)
    );

    assign m_tuser = {out_run_end, out_error};

endmodule
